### rtl/hpmc_pkg.sv
// ----------------------------------------------------------------------------
// hpmc_pkg - shared types and constants of the half-pel motion compensation
// Plane geometry, operation codes, register indexes, sequencer states and
// the control bundle that goes from the sequencer to the tap accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package hpmc_pkg;

  // Plane geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int BLOCK_SIZE = 8;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int YW      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = XW + YW;
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int BLK_W   = $clog2(BLOCK_SIZE);
  localparam int IDX_W   = 2 * BLK_W;
  localparam int NPIX    = BLOCK_SIZE * BLOCK_SIZE;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int MV_W    = 12;
  localparam int CRD_W   = 12;   // signed reference coordinate before clamping
  localparam int DIM_W   = 9;
  localparam int SUM_W   = PIX_W + 2;
  localparam int OP_W    = 3;

  // Stream payload widths (whole bytes)
  localparam int IN_W    = 80;
  localparam int OUT_W   = 16;

  // Register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_WR_FWD   = 3'd0,
    OP_WR_BWD   = 3'd1,
    OP_PRED_FWD = 3'd2,
    OP_PRED_BWD = 3'd3,
    OP_PRED_BI  = 3'd4
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FINISH
  } state_t;

  // Sequencer to accumulator
  typedef struct packed {
    logic       clear;
    logic       add;
    logic [1:0] tap;
  } acc_ctl_t;

endpackage

`default_nettype wire

### rtl/hpmc_ram.sv
// ----------------------------------------------------------------------------
// hpmc_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hpmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/hpmc_addr_gen.sv
// ----------------------------------------------------------------------------
// hpmc_addr_gen - reference tap address
// Adds block column/row and tap offset to the motion-shifted origin, clamps
// the result to the frame and forms the plane address.
// ----------------------------------------------------------------------------
`default_nettype none

module hpmc_addr_gen
  import hpmc_pkg::*;
(
  input  wire logic signed [CRD_W-1:0] org_x,
  input  wire logic signed [CRD_W-1:0] org_y,
  input  wire logic [BLK_W-1:0]        col,
  input  wire logic [BLK_W-1:0]        row,
  input  wire logic                    dx,
  input  wire logic                    dy,
  input  wire logic [XW-1:0]           x_max,
  input  wire logic [YW-1:0]           y_max,
  output      logic [ADDR_W-1:0]       addr
);

  logic signed [CRD_W-1:0] px;
  logic signed [CRD_W-1:0] py;
  logic [XW-1:0]           cx;
  logic [YW-1:0]           cy;

  assign px = org_x + $signed({{(CRD_W-BLK_W){1'b0}}, col})
                    + $signed({{(CRD_W-1){1'b0}}, dx});
  assign py = org_y + $signed({{(CRD_W-BLK_W){1'b0}}, row})
                    + $signed({{(CRD_W-1){1'b0}}, dy});

  // clamp to [0, max]
  always_comb begin
    priority if (px < 0) begin
      cx = '0;
    end else if (px > $signed({{(CRD_W-XW){1'b0}}, x_max})) begin
      cx = x_max;
    end else begin
      cx = px[XW-1:0];
    end
  end

  always_comb begin
    priority if (py < 0) begin
      cy = '0;
    end else if (py > $signed({{(CRD_W-YW){1'b0}}, y_max})) begin
      cy = y_max;
    end else begin
      cy = py[YW-1:0];
    end
  end

  // row * MAX_WIDTH + column
  assign addr = {cy, cx};

endmodule

`default_nettype wire

### rtl/hpmc_accum.sv
// ----------------------------------------------------------------------------
// hpmc_accum - tap accumulator and rounding
// Sums the taps that the vector fractions call for, in both directions at
// once, and forms the rounded one-directional or averaged prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module hpmc_accum
  import hpmc_pkg::*;
(
  input  wire logic             clk,
  input  wire acc_ctl_t         ctl,
  input  wire op_t              op,
  input  wire logic             f_fx,
  input  wire logic             f_fy,
  input  wire logic             b_fx,
  input  wire logic             b_fy,
  input  wire logic [PIX_W-1:0] f_data,
  input  wire logic [PIX_W-1:0] b_data,
  output      logic [PIX_W-1:0] pred
);

  logic [SUM_W-1:0] f_sum;
  logic [SUM_W-1:0] b_sum;
  logic             f_use;
  logic             b_use;
  logic [PIX_W-1:0] f_pred;
  logic [PIX_W-1:0] b_pred;
  logic [PIX_W:0]   bi_sum;

  // tap 0 always, tap 1 with horizontal, tap 2 with vertical, tap 3 with both
  function automatic logic tap_used(logic [1:0] tap, logic fx, logic fy);
    return (tap == 2'd0) || (tap == 2'd1 && fx) || (tap == 2'd2 && fy)
        || (tap == 2'd3 && fx && fy);
  endfunction

  function automatic logic [PIX_W-1:0] round_sum(logic [SUM_W-1:0] s,
                                                  logic fx, logic fy);
    logic [SUM_W-1:0] s1;
    logic [SUM_W-1:0] s2;
    s1 = s + SUM_W'(1);
    s2 = s + SUM_W'(2);
    unique case ({fy, fx})
      2'b00:   return s[PIX_W-1:0];
      2'b11:   return s2[PIX_W+1:2];
      default: return s1[PIX_W:1];
    endcase
  endfunction

  assign f_use = tap_used(ctl.tap, f_fx, f_fy);
  assign b_use = tap_used(ctl.tap, b_fx, b_fy);

  // running tap sums
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      f_sum <= '0;
      b_sum <= '0;
    end else if (ctl.add) begin
      if (f_use) begin
        f_sum <= f_sum + {{(SUM_W-PIX_W){1'b0}}, f_data};
      end
      if (b_use) begin
        b_sum <= b_sum + {{(SUM_W-PIX_W){1'b0}}, b_data};
      end
    end
  end

  // rounding and direction select
  assign f_pred = round_sum(f_sum, f_fx, f_fy);
  assign b_pred = round_sum(b_sum, b_fx, b_fy);
  assign bi_sum = {1'b0, f_pred} + {1'b0, b_pred} + (PIX_W+1)'(1);

  always_comb begin
    unique case (op)
      OP_PRED_FWD: pred = f_pred;
      OP_PRED_BWD: pred = b_pred;
      default:     pred = bi_sum[PIX_W:1];
    endcase
  end

endmodule

`default_nettype wire

### rtl/half_pel_motion_compensation_unit.sv
// ----------------------------------------------------------------------------
// half_pel_motion_compensation_unit - 8x8 half-pel motion compensation
// Forward and backward reference planes with a tap sequencer that turns a
// predict beat into 64 prediction beats in raster order.
// ----------------------------------------------------------------------------
// A write beat stores one pixel. A predict beat is accepted in the idle
// state; each output pixel then passes through the fetch and finish
// states, and finish waits while the output side stalls. In fetch a pixel
// reads its four clamped taps one a cycle through the single read port of
// each plane, the registered read data of each tap lands in the accumulator,
// and in finish the rounded sum is loaded into the output register. Both
// planes are read in parallel, so bidirectional prediction costs the same as
// one direction. The input is not ready while a block is in progress; the last
// pixel may still wait in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module half_pel_motion_compensation_unit
  import hpmc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_index,
  input  wire logic [DIM_W-1:0] cfg_data,
  // input stream
  input  wire logic             s_tvalid,
  output      logic             s_tready,
  // [2:0] operation, [10:3] x_pos, [18:11] y_pos, [26:19] pixel_value,
  // [38:27] fwd_mv_h, [50:39] fwd_mv_v, [62:51] bwd_mv_h, [74:63] bwd_mv_v
  input  wire logic [IN_W-1:0]  s_tdata,
  // output stream
  output      logic             m_tvalid,
  input  wire logic             m_tready,
  // [7:0] pred_pixel, [13:8] pixel_index
  output      logic [OUT_W-1:0] m_tdata,
  output      logic             m_tlast
);

  // input fields
  logic [OP_W-1:0]  in_op;
  logic [XW-1:0]    in_x;
  logic [YW-1:0]    in_y;
  logic [PIX_W-1:0] in_pix;
  logic [MV_W-1:0]  in_fmh;
  logic [MV_W-1:0]  in_fmv;
  logic [MV_W-1:0]  in_bmh;
  logic [MV_W-1:0]  in_bmv;

  assign in_op  = s_tdata[2:0];
  assign in_x   = s_tdata[10:3];
  assign in_y   = s_tdata[18:11];
  assign in_pix = s_tdata[26:19];
  assign in_fmh = s_tdata[38:27];
  assign in_fmv = s_tdata[50:39];
  assign in_bmh = s_tdata[62:51];
  assign in_bmv = s_tdata[74:63];

  // configuration registers
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [XW-1:0]    x_max;
  logic [YW-1:0]    y_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(MAX_WIDTH);
      frame_height <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          ;
      endcase
    end
  end

  // last usable column and row; zero counts as one, oversize as the maximum
  always_comb begin
    priority if (frame_width == '0) begin
      x_max = '0;
    end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
      x_max = XW'(MAX_WIDTH - 1);
    end else begin
      x_max = XW'(frame_width - DIM_W'(1));
    end
  end

  always_comb begin
    priority if (frame_height == '0) begin
      y_max = '0;
    end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
      y_max = YW'(MAX_HEIGHT - 1);
    end else begin
      y_max = YW'(frame_height - DIM_W'(1));
    end
  end

  // sequencer state
  state_t                  state;
  state_t                  state_next;
  op_t                     op;
  logic signed [CRD_W-1:0] f_org_x;
  logic signed [CRD_W-1:0] f_org_y;
  logic signed [CRD_W-1:0] b_org_x;
  logic signed [CRD_W-1:0] b_org_y;
  logic                    f_fx;
  logic                    f_fy;
  logic                    b_fx;
  logic                    b_fy;
  logic [IDX_W-1:0]        pix_idx;
  logic [2:0]              tap;
  logic                    add_pend;
  logic [1:0]              add_tap;

  logic                    s_beat;
  logic                    is_pred;
  logic                    tap_issue;
  logic                    out_free;
  logic                    out_load;
  logic                    last_pix;
  acc_ctl_t                acc_ctl;

  assign s_beat   = s_tvalid && s_tready;
  assign is_pred  = (in_op == OP_PRED_FWD) || (in_op == OP_PRED_BWD)
                 || (in_op == OP_PRED_BI);
  assign out_free = !m_tvalid || m_tready;
  assign last_pix = (pix_idx == IDX_W'(NPIX - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_beat && is_pred) state_next = ST_FETCH;
      ST_FETCH:  if (tap == 3'd4) state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = last_pix ? ST_IDLE : ST_FETCH;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready      = (state == ST_IDLE);
    tap_issue     = (state == ST_FETCH) && !tap[2];
    out_load      = (state == ST_FINISH) && out_free;
    acc_ctl.clear = (state == ST_FETCH) && (tap == 3'd0);
    acc_ctl.add   = add_pend;
    acc_ctl.tap   = add_tap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      add_pend <= 1'b0;
      tap      <= '0;
      pix_idx  <= '0;
    end else begin
      state    <= state_next;
      add_pend <= tap_issue;
      if (state == ST_IDLE) begin
        tap     <= '0;
        pix_idx <= '0;
      end else if (state == ST_FETCH) begin
        if (!tap[2]) begin
          tap <= tap + 3'd1;
        end
      end else if (out_load) begin
        tap     <= '0;
        pix_idx <= pix_idx + IDX_W'(1);
      end
    end
  end

  // the tap whose data returns next cycle
  always_ff @(posedge clk) begin
    add_tap <= tap[1:0];
  end

  // latch the block origin shifted by each vector's integer part
  always_ff @(posedge clk) begin
    if (s_beat && is_pred) begin
      op      <= op_t'(in_op);
      f_org_x <= $signed({{(CRD_W-XW){1'b0}}, in_x})
               + $signed({in_fmh[MV_W-1], in_fmh[MV_W-1:1]});
      f_org_y <= $signed({{(CRD_W-YW){1'b0}}, in_y})
               + $signed({in_fmv[MV_W-1], in_fmv[MV_W-1:1]});
      b_org_x <= $signed({{(CRD_W-XW){1'b0}}, in_x})
               + $signed({in_bmh[MV_W-1], in_bmh[MV_W-1:1]});
      b_org_y <= $signed({{(CRD_W-YW){1'b0}}, in_y})
               + $signed({in_bmv[MV_W-1], in_bmv[MV_W-1:1]});
      f_fx    <= in_fmh[0];
      f_fy    <= in_fmv[0];
      b_fx    <= in_bmh[0];
      b_fy    <= in_bmv[0];
    end
  end

  // tap addresses
  logic [ADDR_W-1:0] f_rd_addr;
  logic [ADDR_W-1:0] b_rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [PIX_W-1:0]  f_rd_data;
  logic [PIX_W-1:0]  b_rd_data;
  logic              f_we;
  logic              b_we;

  hpmc_addr_gen u_f_addr (
    .org_x (f_org_x),
    .org_y (f_org_y),
    .col   (pix_idx[BLK_W-1:0]),
    .row   (pix_idx[IDX_W-1:BLK_W]),
    .dx    (tap[0]),
    .dy    (tap[1]),
    .x_max (x_max),
    .y_max (y_max),
    .addr  (f_rd_addr)
  );

  hpmc_addr_gen u_b_addr (
    .org_x (b_org_x),
    .org_y (b_org_y),
    .col   (pix_idx[BLK_W-1:0]),
    .row   (pix_idx[IDX_W-1:BLK_W]),
    .dx    (tap[0]),
    .dy    (tap[1]),
    .x_max (x_max),
    .y_max (y_max),
    .addr  (b_rd_addr)
  );

  // reference planes; writes land straight from the input beat
  assign wr_addr = {in_y, in_x};
  assign f_we    = s_beat && (in_op == OP_WR_FWD);
  assign b_we    = s_beat && (in_op == OP_WR_BWD);

  hpmc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_fwd_plane (
    .clk     (clk),
    .we      (f_we),
    .wr_addr (wr_addr),
    .wr_data (in_pix),
    .rd_addr (f_rd_addr),
    .rd_data (f_rd_data)
  );

  hpmc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_bwd_plane (
    .clk     (clk),
    .we      (b_we),
    .wr_addr (wr_addr),
    .wr_data (in_pix),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  // tap accumulation and rounding
  logic [PIX_W-1:0] pred;

  hpmc_accum u_accum (
    .clk    (clk),
    .ctl    (acc_ctl),
    .op     (op),
    .f_fx   (f_fx),
    .f_fy   (f_fy),
    .b_fx   (b_fx),
    .b_fy   (b_fy),
    .f_data (f_rd_data),
    .b_data (b_rd_data),
    .pred   (pred)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(OUT_W-IDX_W-PIX_W){1'b0}}, pix_idx, pred};
      m_tlast <= last_pix;
    end
  end

endmodule

`default_nettype wire
